/* hw/rtl/u8d_pkg.sv */
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; used by every module under hw/rtl.

package u8d_pkg;

  localparam int ByteW   = 8;
  localparam int CodeW   = 21;
  localparam int PendW   = 2;
  localparam int QDepth  = 3;
  localparam int QCountW = 2;

  // Top two bits of a continuation byte
  localparam logic [1:0] ContTag = 2'b10;
  // Replacement character '?'
  localparam logic [CodeW-1:0] Replacement = 21'h00003F;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [PendW-1:0] pend_t;

  typedef struct packed {
    code_t code_point;
    logic  malformed;
    logic  end_of_text;
    logic  last;
  } u8d_result_t;

  // Results produced by one accepted byte: zero, one or two
  typedef struct packed {
    logic [1:0]  count;
    u8d_result_t first;
    u8d_result_t second;
  } u8d_push_t;

endpackage

/* hw/rtl/utf8_codepoint_decoder_unit.sv */
// Top level of the UTF-8 code point decoder: byte decoder feeding a result queue.
// Depends on u8d_pkg, u8d_decode and u8d_out_queue.

// Takes one UTF-8 byte per transfer on text_byte and returns decoded code points,
// one result item per transfer out. A byte's results are in the output queue the
// cycle after it is accepted. A full sequence byte, an ASCII byte or a terminator
// gives one result, a lead or inner continuation byte gives none, and a byte that
// breaks an open sequence gives '?' with malformed set, then the byte's own result
// if it has one; last marks the final result of a byte. The three-entry output
// queue takes a byte whenever it holds at most one result, so with the output
// side draining, one byte per cycle is sustained and only a two-result byte
// stalls the input. A zero byte yields code point 0 with end_of_text.

module utf8_codepoint_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [u8d_pkg::ByteW-1:0]     text_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u8d_pkg::CodeW-1:0]     code_point,
  output logic                          malformed,
  output logic                          end_of_text,
  output logic                          last
);

  logic                 accept;
  logic                 room;
  u8d_pkg::u8d_push_t   push;
  u8d_pkg::u8d_result_t head;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  u8d_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_byte),
    .push      (push)
  );

  u8d_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign code_point  = head.code_point;
  assign malformed   = head.malformed;
  assign end_of_text = head.end_of_text;
  assign last        = head.last;

endmodule

/* hw/rtl/u8d_decode.sv */
// Sequence state and byte decoding for the UTF-8 code point decoder.
// Depends on u8d_pkg.

module u8d_decode (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [u8d_pkg::ByteW-1:0] text_byte,
  output u8d_pkg::u8d_push_t       push
);

  u8d_pkg::pend_t bytes_pending, bytes_pending_next;
  u8d_pkg::code_t partial_code, partial_code_next;

  logic           is_cont;
  logic           broken;
  logic           lead_emits;
  u8d_pkg::u8d_result_t lead_res;
  u8d_pkg::pend_t lead_pend;
  u8d_pkg::code_t lead_code;
  u8d_pkg::code_t shifted;

  assign is_cont = (text_byte[7:6] == u8d_pkg::ContTag);
  assign broken  = (bytes_pending != '0) && !is_cont;
  assign shifted = {partial_code[u8d_pkg::CodeW-7:0], text_byte[5:0]};

  // Handle the byte as the start of something new
  always_comb begin
    lead_emits = 1'b0;
    lead_res   = '{code_point: '0, malformed: 1'b0, end_of_text: 1'b0, last: 1'b1};
    lead_pend  = '0;
    lead_code  = '0;
    if (text_byte == '0) begin
      lead_emits           = 1'b1;
      lead_res.end_of_text = 1'b1;
    end else if (!text_byte[7]) begin
      lead_emits          = 1'b1;
      lead_res.code_point = u8d_pkg::CodeW'(text_byte);
    end else if (text_byte[7:5] == 3'b110) begin
      lead_pend = 2'd1;
      lead_code = u8d_pkg::CodeW'(text_byte[4:0]);
    end else if (text_byte[7:4] == 4'b1110) begin
      lead_pend = 2'd2;
      lead_code = u8d_pkg::CodeW'(text_byte[3:0]);
    end else if (text_byte[7:3] == 5'b11110) begin
      lead_pend = 2'd3;
      lead_code = u8d_pkg::CodeW'(text_byte[2:0]);
    end else begin
      // stray continuation or 0xF8 and above
      lead_emits          = 1'b1;
      lead_res.code_point = u8d_pkg::Replacement;
      lead_res.malformed  = 1'b1;
    end
  end

  always_comb begin
    push               = '0;
    bytes_pending_next = bytes_pending;
    partial_code_next  = partial_code;
    if (bytes_pending != '0 && is_cont) begin
      if (bytes_pending == 2'd1) begin
        push.count        = 2'd1;
        push.first        = '{code_point: shifted, malformed: 1'b0,
                              end_of_text: 1'b0, last: 1'b1};
        bytes_pending_next = '0;
        partial_code_next  = '0;
      end else begin
        bytes_pending_next = bytes_pending - 2'd1;
        partial_code_next  = shifted;
      end
    end else begin
      bytes_pending_next = lead_pend;
      partial_code_next  = lead_code;
      if (broken) begin
        // drop the open sequence, then handle the byte as a new lead
        push.first = '{code_point: u8d_pkg::Replacement, malformed: 1'b1,
                       end_of_text: 1'b0, last: !lead_emits};
        if (lead_emits) begin
          push.count  = 2'd2;
          push.second = lead_res;
        end else begin
          push.count = 2'd1;
        end
      end else if (lead_emits) begin
        push.count = 2'd1;
        push.first = lead_res;
      end
    end
    if (!accept) begin
      push.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      partial_code  <= '0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      partial_code  <= partial_code_next;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    bytes_pending == '0 |-> partial_code == '0)
    else $error("partial code not cleared with no sequence open");

  a_two_needs_open: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> bytes_pending != '0 && push.first.malformed)
    else $error("two results without a broken sequence");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd3)
    else $error("more than two results for one byte");

  a_first_last: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> !push.first.last && push.second.last)
    else $error("last flag misplaced on a two-result byte");

endmodule

/* hw/rtl/u8d_out_queue.sv */
// Three-entry result queue with head at entry 0; parts the decoder from the output.
// Depends on u8d_pkg.

module u8d_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  u8d_pkg::u8d_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output u8d_pkg::u8d_result_t head
);

  u8d_pkg::u8d_result_t entry      [u8d_pkg::QDepth];
  u8d_pkg::u8d_result_t entry_next [u8d_pkg::QDepth];
  logic [u8d_pkg::QCountW-1:0] count, count_next;
  logic [u8d_pkg::QCountW-1:0] count_popped;
  logic pop;

  assign pop       = (count != '0) && !out_stall;
  assign out_valid = (count != '0);
  assign head      = entry[0];
  // Registered count keeps stall off any combinational path
  assign room      = (count <= 2'd1);

  assign count_popped = count - {1'b0, pop};
  assign count_next   = count_popped + push.count;

  always_comb begin
    for (int i = 0; i < u8d_pkg::QDepth; i++) begin
      // shift toward the head on a transfer out
      if (pop && i < u8d_pkg::QDepth - 1) begin
        entry_next[i] = entry[i+1];
      end else begin
        entry_next[i] = entry[i];
      end
      if (push.count != '0 && u8d_pkg::QCountW'(i) == count_popped) begin
        entry_next[i] = push.first;
      end else if (push.count == 2'd2 &&
                   u8d_pkg::QCountW'(i) == count_popped + 2'd1) begin
        entry_next[i] = push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < u8d_pkg::QDepth; i++) begin
      entry[i] <= entry_next[i];
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.count != '0 |-> room)
    else $error("push into a full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) - {1'b0, $past(pop)} + $past(push.count))
    else $error("queue count out of step");

  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(head))
    else $error("held result changed");

endmodule
